/* sv/frt_pkg.sv */
package frt_pkg;

   localparam int BUFFER_DEPTH_DEF = 512;
   localparam int MAX_WORDS_DEF    = 50;

   // Fixed field widths of the stream payload
   localparam int POS_W   = 9;
   localparam int INDEX_W = 6;
   localparam int DATA_W  = 8;
   localparam int KIND_W  = 2;

   localparam logic [KIND_W-1:0] KIND_WORD  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_READ    = 1'b1;

   localparam logic [DATA_W-1:0] CH_END   = 8'h3B;
   localparam logic [DATA_W-1:0] CH_START = 8'h24;
   localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
   localparam logic [DATA_W-1:0] CH_COMMA = 8'h2C;

   // Commands from the sequencer to the word scanner
   typedef struct packed {
      logic clear;   // new message: drop word count
      logic step;    // one message byte at pos
      logic delim;   // that byte is a separator
      logic close;   // message ends at pos
   } scan_cmd_type;

   function automatic logic is_delim(input logic [DATA_W-1:0] c);
      return (c == CH_SPACE) || (c == CH_COMMA);
   endfunction

endpackage

/* sv/frame_receive_and_tokenize.sv */
// Frame receiver and word tokenizer. Requests carry either a received byte
// (tuser 0) or a message read (tuser 1). A '$' opens a frame, bytes are kept
// in the receive memory, and ';' ends it: the content up to the first zero
// byte is copied into the message memory while words (runs without space or
// comma) are logged in a word memory (at most MAX_WORDS of them), then one
// descriptor per logged word is sent, or a single empty notice. A read waits
// in a read state for the message memory. A ';' with content starts the
// receive memory read, copies one byte per step (with one more step when a
// zero byte cuts the copy), closes the last word, then reads the word memory
// for each word descriptor or goes to the empty notice. A ';' with no content
// skips the copy. Results wait on rsp_tready. No clearing pass is needed
// after reset.
module frame_receive_and_tokenize #(
   parameter int BUFFER_DEPTH = frt_pkg::BUFFER_DEPTH_DEF,
   parameter int MAX_WORDS    = frt_pkg::MAX_WORDS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // rx_byte[7:0], read_addr[16:8], zero fill
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // word_index[5:0], word_start[14:6],
                                    // word_length[23:15], word_total[29:24],
                                    // read_data[37:30], zero fill
   output logic [1:0]  rsp_tuser,   // result_kind
   output logic        rsp_tlast    // last
);

   import frt_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int NW = $clog2(MAX_WORDS + 1);
   localparam int WA = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
   localparam int CW = (AW > POS_W) ? AW : POS_W;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_COPY0   = 4'd1;
   localparam logic [3:0] ST_COPY    = 4'd2;
   localparam logic [3:0] ST_CLOSE   = 4'd3;
   localparam logic [3:0] ST_EMIT_RD = 4'd4;
   localparam logic [3:0] ST_EMIT_WR = 4'd5;
   localparam logic [3:0] ST_EMPTY   = 4'd6;
   localparam logic [3:0] ST_READ    = 4'd7;

   logic [3:0]    state_ff, state_in;
   logic          in_frame_ff, in_frame_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [AW-1:0] content_len_ff, content_len_in;
   logic [AW-1:0] msg_len_ff, msg_len_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] raddr_ff, raddr_in;
   logic          hit_ff, hit_in;
   logic [WA-1:0] emit_ff, emit_in;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_total_ff;
   logic [POS_W-1:0]  rsp_start_ff, rsp_length_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;

   logic              push;
   logic [KIND_W-1:0] push_kind;
   logic [INDEX_W-1:0] push_index, push_total;
   logic [POS_W-1:0]  push_start, push_length;
   logic [DATA_W-1:0] push_data;
   logic              push_last;
   logic              out_free;

   logic              opcode;
   logic [DATA_W-1:0] rx_byte;
   logic [POS_W-1:0]  read_addr;
   logic              accept;
   logic [AW-1:0]     wr_next, idx_next;
   logic              wr_at_end;

   logic              rx_we;
   logic [AW-1:0]     rx_raddr;
   logic [DATA_W-1:0] rx_rdata;
   logic              msg_we;
   logic [AW-1:0]     msg_raddr;
   logic [DATA_W-1:0] msg_rdata;

   scan_cmd_type      scan_cmd;
   logic [AW-1:0]     scan_pos;
   logic [NW-1:0]     words_found;
   logic [AW-1:0]     word_start, word_length;
   logic              emit_last;

   assign opcode    = req_tuser;
   assign rx_byte   = req_tdata[7:0];
   assign read_addr = req_tdata[16:8];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign wr_at_end = (wr_idx_ff == AW'(BUFFER_DEPTH - 1));
   assign wr_next   = wr_at_end ? '0 : wr_idx_ff + AW'(1);
   assign idx_next  = idx_ff + AW'(1);
   assign emit_last = ((NW'(emit_ff) + NW'(1)) == words_found);

   always_comb begin
      state_in       = state_ff;
      in_frame_in    = in_frame_ff;
      wr_idx_in      = wr_idx_ff;
      content_len_in = content_len_ff;
      msg_len_in     = msg_len_ff;
      idx_in         = idx_ff;
      raddr_in       = raddr_ff;
      hit_in         = hit_ff;
      emit_in        = emit_ff;
      rx_we          = 1'b0;
      msg_we         = 1'b0;
      rx_raddr       = idx_next;
      scan_cmd       = '0;
      scan_pos       = idx_ff;
      push           = 1'b0;
      push_kind      = KIND_WORD;
      push_index     = '0;
      push_start     = '0;
      push_length    = '0;
      push_total     = '0;
      push_data      = '0;
      push_last      = 1'b1;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (opcode == OP_READ) begin
                  raddr_in = AW'(CW'(read_addr));
                  hit_in   = CW'(read_addr) < CW'(msg_len_ff);
                  state_in = ST_READ;
               end else begin
                  if (in_frame_ff) begin
                     rx_we     = 1'b1;
                     wr_idx_in = wr_next;
                     if (rx_byte == CH_END) begin
                        // ';' landing on the last slot leaves an empty message
                        content_len_in = wr_at_end ? '0 : wr_idx_ff;
                        wr_idx_in      = '0;
                        in_frame_in    = 1'b0;
                        scan_cmd.clear = 1'b1;
                        if (wr_at_end || (wr_idx_ff == '0)) begin
                           msg_len_in = '0;
                           state_in   = ST_CLOSE;
                        end else begin
                           state_in = ST_COPY0;
                        end
                     end
                  end
                  if (rx_byte == CH_START) begin
                     wr_idx_in   = '0;
                     in_frame_in = 1'b1;
                  end
               end
            end
         end
         ST_COPY0: begin
            rx_raddr = '0;
            idx_in   = '0;
            state_in = ST_COPY;
         end
         ST_COPY: begin
            if (rx_rdata == '0) begin
               msg_len_in = idx_ff;
               state_in   = ST_CLOSE;
            end else begin
               msg_we         = 1'b1;
               scan_cmd.step  = 1'b1;
               scan_cmd.delim = is_delim(rx_rdata);
               if (idx_next == content_len_ff) begin
                  msg_len_in = idx_next;
                  state_in   = ST_CLOSE;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         ST_CLOSE: begin
            scan_cmd.close = 1'b1;
            scan_pos       = msg_len_ff;
            emit_in        = '0;
            state_in       = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            state_in = (words_found == '0) ? ST_EMPTY : ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (out_free) begin
               push        = 1'b1;
               push_kind   = KIND_WORD;
               push_index  = INDEX_W'(emit_ff);
               push_start  = POS_W'(CW'(word_start));
               push_length = POS_W'(CW'(word_length));
               push_total  = INDEX_W'(words_found);
               push_last   = emit_last;
               if (emit_last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_in  = emit_ff + WA'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMPTY: begin
            if (out_free) begin
               push      = 1'b1;
               push_kind = KIND_EMPTY;
               state_in  = ST_IDLE;
            end
         end
         ST_READ: begin
            if (out_free) begin
               push      = 1'b1;
               push_kind = KIND_READ;
               push_data = hit_ff ? msg_rdata : '0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign msg_raddr = (state_ff == ST_IDLE) ? AW'(CW'(read_addr)) : raddr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_frame_ff  <= 1'b0;
         wr_idx_ff    <= '0;
         msg_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_frame_ff <= in_frame_in;
         wr_idx_ff   <= wr_idx_in;
         msg_len_ff  <= msg_len_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      content_len_ff <= content_len_in;
      idx_ff         <= idx_in;
      raddr_ff       <= raddr_in;
      hit_ff         <= hit_in;
      emit_ff        <= emit_in;
      if (push) begin
         rsp_kind_ff   <= push_kind;
         rsp_index_ff  <= push_index;
         rsp_start_ff  <= push_start;
         rsp_length_ff <= push_length;
         rsp_total_ff  <= push_total;
         rsp_data_ff   <= push_data;
         rsp_last_ff   <= push_last;
      end
   end

   frt_ram #(
      .WIDTH(DATA_W),
      .DEPTH(BUFFER_DEPTH)
   ) u_rx_ram (
      .clock  (clock),
      .wr_en  (rx_we),
      .wr_addr(wr_idx_ff),
      .wr_data(rx_byte),
      .rd_addr(rx_raddr),
      .rd_data(rx_rdata)
   );

   frt_ram #(
      .WIDTH(DATA_W),
      .DEPTH(BUFFER_DEPTH)
   ) u_msg_ram (
      .clock  (clock),
      .wr_en  (msg_we),
      .wr_addr(idx_ff),
      .wr_data(rx_rdata),
      .rd_addr(msg_raddr),
      .rd_data(msg_rdata)
   );

   frt_word_scan #(
      .BUFFER_DEPTH(BUFFER_DEPTH),
      .MAX_WORDS   (MAX_WORDS)
   ) u_word_scan (
      .clock      (clock),
      .reset      (reset),
      .cmd        (scan_cmd),
      .pos        (scan_pos),
      .words_found(words_found),
      .rd_addr    (emit_ff),
      .rd_start   (word_start),
      .rd_length  (word_length)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff, rsp_total_ff, rsp_length_ff,
                        rsp_start_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* sv/frt_ram.sv */
module frt_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/frt_word_scan.sv */
module frt_word_scan #(
   parameter int BUFFER_DEPTH = frt_pkg::BUFFER_DEPTH_DEF,
   parameter int MAX_WORDS    = frt_pkg::MAX_WORDS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  frt_pkg::scan_cmd_type                 cmd,
   input  logic [$clog2(BUFFER_DEPTH)-1:0]       pos,
   output logic [$clog2(MAX_WORDS+1)-1:0]        words_found,
   input  logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] rd_addr,
   output logic [$clog2(BUFFER_DEPTH)-1:0]       rd_start,
   output logic [$clog2(BUFFER_DEPTH)-1:0]       rd_length
);

   import frt_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int NW = $clog2(MAX_WORDS + 1);
   localparam int WA = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

   logic          in_word_ff, in_word_in;
   logic [AW-1:0] start_ff, start_in;
   logic [NW-1:0] count_ff, count_in;
   logic          wr_en;
   logic [2*AW-1:0] wr_data, rd_data;

   always_comb begin
      in_word_in = in_word_ff;
      start_in   = start_ff;
      count_in   = count_ff;
      wr_en      = 1'b0;
      if (cmd.clear) begin
         in_word_in = 1'b0;
         count_in   = '0;
      end else if (cmd.step) begin
         if (cmd.delim) begin
            if (in_word_ff) begin
               wr_en      = 1'b1;
               count_in   = count_ff + NW'(1);
               in_word_in = 1'b0;
            end
         end else if (!in_word_ff && (count_ff < NW'(MAX_WORDS))) begin
            start_in   = pos;
            in_word_in = 1'b1;
         end
      end else if (cmd.close && in_word_ff) begin
         wr_en      = 1'b1;
         count_in   = count_ff + NW'(1);
         in_word_in = 1'b0;
      end
   end

   assign wr_data = {pos - start_ff, start_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         in_word_ff <= in_word_in;
         count_ff   <= count_in;
      end
      start_ff <= start_in;
   end

   frt_ram #(
      .WIDTH(2 * AW),
      .DEPTH(MAX_WORDS)
   ) u_word_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(count_ff[WA-1:0]),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign words_found = count_ff;
   assign rd_start    = rd_data[AW-1:0];
   assign rd_length   = rd_data[2*AW-1:AW];

endmodule

/* tb/tb_frame_receive_and_tokenize.sv */
`timescale 1ns / 100ps

module tb_frame_receive_and_tokenize;

   import frt_pkg::*;

   typedef struct {
      logic [KIND_W-1:0]  kind;
      logic [INDEX_W-1:0] index;
      logic [POS_W-1:0]   start;
      logic [POS_W-1:0]   length;
      logic [INDEX_W-1:0] total;
      logic [DATA_W-1:0]  data;
      logic               last;
   } token_result_type;

   class token_scoreboard;
      logic                  in_frame;
      int unsigned           wr_index;
      logic [DATA_W-1:0]     rx_mem  [BUFFER_DEPTH_DEF];
      logic [DATA_W-1:0]     msg_mem [BUFFER_DEPTH_DEF];
      int unsigned           msg_len;
      token_result_type      expected_q [$];
      int unsigned           errors;
      int unsigned           accepted;
      int unsigned           ignored;
      int unsigned           frames;
      int unsigned           words_seen;
      int unsigned           notices_seen;
      int unsigned           reads_seen;

      function new();
         in_frame = 1'b0;
         wr_index = 0;
         msg_len = 0;
         errors = 0;
         accepted = 0;
         ignored = 0;
         frames = 0;
         words_seen = 0;
         notices_seen = 0;
         reads_seen = 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // copy up to the first zero byte, then split on space and comma
      function void close_frame(input int unsigned content_len);
         int unsigned      starts [MAX_WORDS_DEF];
         int unsigned      lens   [MAX_WORDS_DEF];
         int unsigned      n;
         int unsigned      i;
         token_result_type r;
         n = 0;
         i = 0;
         frames++;
         while (i < content_len && rx_mem[i] != 8'h00) i++;
         for (int unsigned k = 0; k < i; k++) msg_mem[k] = rx_mem[k];
         msg_len = i;
         i = 0;
         while (i < msg_len && n < MAX_WORDS_DEF) begin
            while (i < msg_len && (msg_mem[i] == CH_SPACE || msg_mem[i] == CH_COMMA)) i++;
            if (i >= msg_len) break;
            starts[n] = i;
            while (i < msg_len && !(msg_mem[i] == CH_SPACE || msg_mem[i] == CH_COMMA)) i++;
            lens[n] = i - starts[n];
            n++;
         end
         r.data = '0;
         if (n == 0) begin
            r.kind = KIND_EMPTY;
            r.index = '0;
            r.start = '0;
            r.length = '0;
            r.total = '0;
            r.last = 1'b1;
            expected_q.push_back(r);
         end else begin
            for (int unsigned k = 0; k < n; k++) begin
               r.kind = KIND_WORD;
               r.index = k[INDEX_W-1:0];
               r.start = starts[k][POS_W-1:0];
               r.length = lens[k][POS_W-1:0];
               r.total = n[INDEX_W-1:0];
               r.last = (k + 1 == n);
               expected_q.push_back(r);
            end
         end
      endfunction

      function void note_request(input logic op, input logic [7:0] c, input logic [8:0] addr);
         token_result_type r;
         int unsigned      pos;
         int unsigned      nxt;
         accepted++;
         if (op == OP_READ) begin
            r.kind = KIND_READ;
            r.index = '0;
            r.start = '0;
            r.length = '0;
            r.total = '0;
            r.data = (addr < msg_len) ? msg_mem[addr] : 8'h00;
            r.last = 1'b1;
            expected_q.push_back(r);
            return;
         end
         if (!in_frame && c != CH_START) ignored++;
         if (in_frame) begin
            pos = (wr_index >= BUFFER_DEPTH_DEF) ? 0 : wr_index;
            rx_mem[pos] = c;
            nxt = pos + 1;
            if (nxt >= BUFFER_DEPTH_DEF) nxt = 0;
            wr_index = nxt;
            if (c == CH_END) begin
               wr_index = 0;
               in_frame = 1'b0;
               // a ';' landing on the wrap leaves an empty message
               close_frame((nxt == 0) ? 0 : pos);
            end
         end
         if (c == CH_START) begin
            wr_index = 0;
            in_frame = 1'b1;
         end
      endfunction

      function bit field_ok(input string name, input logic [8:0] want, input logic [8:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_response(input logic [1:0] kind, input logic [39:0] d,
                                   input logic last);
         token_result_type want;
         bit               ok;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual kind %0h tdata %0h last %0b",
                     $time, kind, d, last);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         ok = field_ok("result_kind", want.kind, kind);
         ok &= field_ok("word_index", want.index, d[5:0]);
         ok &= field_ok("word_start", want.start, d[14:6]);
         ok &= field_ok("word_length", want.length, d[23:15]);
         ok &= field_ok("word_total", want.total, d[29:24]);
         ok &= field_ok("read_data", want.data, d[37:30]);
         ok &= field_ok("last", want.last, last);
         if (!ok) errors++;
         case (want.kind)
            KIND_WORD:  words_seen++;
            KIND_EMPTY: notices_seen++;
            default:    reads_seen++;
         endcase
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // rx_byte[7:0], read_addr[16:8], zero fill
   logic        req_tuser;    // opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;    // word_index[5:0], word_start[14:6], word_length[23:15],
                              // word_total[29:24], read_data[37:30], zero fill
   logic [1:0]  rsp_tuser;    // result_kind
   logic        rsp_tlast;    // last

   token_scoreboard sb = new();

   bit          steady = 1'b0;
   int unsigned holds_asked = 0;
   int unsigned holds_done = 0;
   int unsigned hold_left = 0;

   frame_receive_and_tokenize DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // response side: random stalls plus the occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         rsp_tready <= 1'b0;
         hold_left <= 400;
         holds_done <= holds_done + 1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input logic op, input logic [7:0] b, input logic [8:0] a);
      while (!steady && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, a, b};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, b, a);
      @(negedge clock);
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_request(OP_RECEIVE, b, 9'($urandom_range(511)));
   endtask

   task automatic send_read(input logic [8:0] a);
      send_request(OP_READ, 8'($urandom_range(255)), a);
   endtask

   function automatic logic [7:0] pick_text_byte(input int unsigned zero_pct);
      int unsigned roll;
      logic [7:0]  b;
      roll = $urandom_range(99);
      if (roll < zero_pct) return 8'h00;
      if (roll < 40) return 8'h61 + 8'($urandom_range(25));
      if (roll < 60) return CH_SPACE;
      if (roll < 70) return CH_COMMA;
      b = 8'($urandom_range(255));
      while (b == CH_START || b == CH_END) b = 8'($urandom_range(255));
      return b;
   endfunction

   task automatic send_frame(input int unsigned len, input int unsigned zero_pct);
      send_byte(CH_START);
      repeat (len) send_byte(pick_text_byte(zero_pct));
      send_byte(CH_END);
   endtask

   task automatic send_many_words(input int unsigned count, input bit with_hold);
      send_byte(CH_START);
      repeat (count) begin
         repeat ($urandom_range(1, 2)) send_byte(8'h61 + 8'($urandom_range(25)));
         send_byte($urandom_range(1) ? CH_SPACE : CH_COMMA);
      end
      if (with_hold) holds_asked++;
      send_byte(CH_END);
   endtask

   task automatic send_reads(input int unsigned count);
      repeat (count) begin
         if ($urandom_range(99) < 70) send_read(9'($urandom_range(24)));
         else send_read(9'($urandom_range(511)));
      end
   endtask

   initial begin
      int unsigned roll;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_RECEIVE;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reads of the empty message, bytes outside any frame
      send_read(9'd0);
      send_read(9'd511);
      send_byte(8'h78);
      send_byte(8'hFF);
      // "ab c,,d" -> three words
      send_byte(CH_START);
      send_byte(8'h61);
      send_byte(8'h62);
      send_byte(CH_SPACE);
      send_byte(8'h63);
      send_byte(CH_COMMA);
      send_byte(CH_COMMA);
      send_byte(8'h64);
      send_byte(CH_END);
      send_read(9'd6);
      send_read(9'd7);
      // separators only -> empty notice
      send_byte(CH_START);
      send_byte(CH_SPACE);
      send_byte(CH_COMMA);
      send_byte(CH_END);
      // restart inside a frame, then a zero byte cuts the message
      send_byte(CH_START);
      send_byte(8'h71);
      send_byte(CH_START);
      send_byte(8'h72);
      send_byte(8'h00);
      send_byte(8'h73);
      send_byte(CH_END);
      // empty frame
      send_byte(CH_START);
      send_byte(CH_END);

      // word limit overflow while the response side holds off
      send_many_words(MAX_WORDS_DEF + 5, 1'b1);
      send_reads(12);
      send_frame(10, 0);

      while (sb.accepted < 430) begin
         steady = (sb.accepted >= 260 && sb.accepted < 350);
         roll = $urandom_range(99);
         if (roll < 45) begin
            send_frame($urandom_range(16), 0);
            send_reads($urandom_range(3));
         end else if (roll < 55) begin
            send_frame($urandom_range(1, 16), 15);
            send_reads($urandom_range(1, 3));
         end else if (roll < 65) begin
            send_byte(CH_START);
            repeat ($urandom_range(1, 6)) send_byte(pick_text_byte(0));
            send_frame($urandom_range(8), 0);
         end else if (roll < 72) begin
            send_byte(8'($urandom_range(255)));
         end else if (roll < 90) begin
            send_reads($urandom_range(1, 4));
         end else if (roll < 97) begin
            send_frame($urandom_range(17, 40), 3);
         end else begin
            send_many_words($urandom_range(3, 12), 1'b0);
         end
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (700) @(posedge clock);

      $display("Covered %0d requests (%0d ignored) over %0d closed frames,",
               sb.accepted, sb.ignored, sb.frames);
      $display("checking %0d word descriptors, %0d empty notices and %0d store reads.",
               sb.words_seen, sb.notices_seen, sb.reads_seen);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
